@@ rtl/mm4_pkg.sv @@
package mm4_pkg;

	localparam int unsigned DIM_DEF = 4;

	typedef enum logic [1:0] {
		CMD_LOAD_LEFT  = 2'd0,
		CMD_LOAD_RIGHT = 2'd1,
		CMD_MULTIPLY   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         product_index;
		logic signed [31:0] product_value;
		logic               last_element;
	} out_item_t;

endpackage

@@ rtl/matrix_multiply_4x4.sv @@
// Load beats are accepted one per cycle, back to back, while busy is low.
// A multiply beat keeps busy high until its last product is strobed; one shared
// 32x32 multiplier and accumulator take one term per cycle, then three pipeline stages.
// Products come out in row-major order, each once its DIM terms are accumulated.
// Results are strobed for one cycle each and the receiver cannot stall them.
// The asynchronous reset clears both matrices to zero through per-entry valid bits.
module matrix_multiply_4x4 #(
	parameter int unsigned DIM = mm4_pkg::DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mm4_pkg::in_item_t   item,
	output logic                strobe,
	output mm4_pkg::out_item_t  result
);

	localparam int unsigned CELLS   = DIM * DIM;
	localparam int unsigned CELL_AW = $clog2(CELLS);
	localparam int unsigned RC_W    = $clog2(DIM);
	localparam int unsigned LD_W    = (CELL_AW + 1 > 4) ? CELL_AW + 1 : 4;
	localparam int unsigned ACC_W   = 64 + $clog2(DIM);
	localparam int unsigned SH_W    = ACC_W - 16;

	mm4_pkg::state_t state_q, state_d;

	logic [31:0] left_mem  [CELLS];
	logic [31:0] right_mem [CELLS];
	logic [CELLS-1:0] left_vld_q, right_vld_q;

	logic accept, issue, issue_last_k, issue_first_k, issue_done;
	logic [LD_W-1:0]    ld_idx;
	logic               ld_ok;
	logic [CELL_AW-1:0] wr_addr, left_addr, right_addr;
	logic [RC_W-1:0]    row_q, col_q, k_q;
	logic [LD_W-1:0]    pos;

	logic               valid_s1, first_s1, last_k_s1, last_s1;
	logic [3:0]         idx_s1;
	logic [31:0]        left_s1, right_s1;
	logic               left_vld_s1, right_vld_s1;
	logic signed [31:0] a_op, b_op;

	logic               valid_s2, first_s2, last_k_s2, last_s2;
	logic [3:0]         idx_s2;
	logic signed [63:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q, acc_d;
	logic signed [SH_W-1:0]  shifted;
	logic [SH_W-32:0]        top_bits;
	logic                    fits;
	logic [31:0]             sat_value;

	assign accept  = start && !busy;
	assign ld_idx  = LD_W'(item.element_index);
	assign ld_ok   = ld_idx < LD_W'(CELLS);
	assign wr_addr = ld_idx[CELL_AW-1:0];

	assign left_addr  = CELL_AW'(row_q) * CELL_AW'(DIM) + CELL_AW'(k_q);
	assign right_addr = CELL_AW'(k_q) * CELL_AW'(DIM) + CELL_AW'(col_q);
	assign pos        = LD_W'(row_q) * LD_W'(DIM) + LD_W'(col_q);

	assign issue_first_k = k_q == '0;
	assign issue_last_k  = k_q == RC_W'(DIM - 1);
	assign issue_done    = issue_last_k && (col_q == RC_W'(DIM - 1))
		&& (row_q == RC_W'(DIM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		busy    = 1'b1;
		case (state_q)
			mm4_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && item.command == mm4_pkg::CMD_MULTIPLY) begin
					state_d = mm4_pkg::ST_RUN;
				end
			end
			mm4_pkg::ST_RUN: begin
				issue = 1'b1;
				if (issue_done) begin
					state_d = mm4_pkg::ST_DRAIN;
				end
			end
			mm4_pkg::ST_DRAIN: begin
				if (strobe && result.last_element) begin
					state_d = mm4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mm4_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			k_q   <= '0;
		end else if (issue) begin
			if (issue_last_k) begin
				k_q <= '0;
				if (col_q == RC_W'(DIM - 1)) begin
					col_q <= '0;
					row_q <= issue_done ? '0 : row_q + RC_W'(1);
				end else begin
					col_q <= col_q + RC_W'(1);
				end
			end else begin
				k_q <= k_q + RC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_vld_q  <= '0;
			right_vld_q <= '0;
		end else if (accept && ld_ok) begin
			if (item.command == mm4_pkg::CMD_LOAD_LEFT) begin
				left_vld_q[wr_addr] <= 1'b1;
			end
			if (item.command == mm4_pkg::CMD_LOAD_RIGHT) begin
				right_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ld_ok && item.command == mm4_pkg::CMD_LOAD_LEFT) begin
			left_mem[wr_addr] <= item.element_value;
		end
		left_s1     <= left_mem[left_addr];
		left_vld_s1 <= left_vld_q[left_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && ld_ok && item.command == mm4_pkg::CMD_LOAD_RIGHT) begin
			right_mem[wr_addr] <= item.element_value;
		end
		right_s1     <= right_mem[right_addr];
		right_vld_s1 <= right_vld_q[right_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign a_op = left_vld_s1  ? $signed(left_s1)  : '0;
	assign b_op = right_vld_s1 ? $signed(right_s1) : '0;

	always_ff @(posedge clk) begin
		first_s1  <= issue_first_k;
		last_k_s1 <= issue_last_k;
		last_s1   <= issue_done;
		idx_s1    <= pos[3:0];
		first_s2  <= first_s1;
		last_k_s2 <= last_k_s1;
		last_s2   <= last_s1;
		idx_s2    <= idx_s1;
		prod_s2   <= 64'(a_op) * 64'(b_op);
	end

	assign acc_d    = first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	assign shifted  = SH_W'(acc_d >>> 16);
	assign top_bits = shifted[SH_W-1:31];
	assign fits     = (&top_bits) || !(|top_bits);
	assign sat_value = fits ? shifted[31:0]
		: (shifted[SH_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= acc_d;
		end
		if (valid_s2 && last_k_s2) begin
			result.product_index <= idx_s2;
			result.product_value <= $signed(sat_value);
			result.last_element  <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s2 && last_k_s2;
		end
	end

endmodule

@@ verif/tb_matrix_multiply_4x4.sv @@
`timescale 1ns / 1ps

module tb_matrix_multiply_4x4;

	localparam int unsigned DIM = mm4_pkg::DIM_DEF;
	localparam int unsigned CELLS = DIM * DIM;
	localparam int unsigned MUL_CYCLES = DIM * DIM * DIM + 4;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_BEATS = 400;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		mm4_pkg::in_item_t  beat;
		logic               typed;
		logic signed [31:0] value0;
	} dir_row_t;

	localparam int unsigned NUM_ROWS = 22;

	// Rows with typed set carry the product element at position zero as read off by hand.
	dir_row_t directed_rows [NUM_ROWS] = '{
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b1, 32'sh00000000},
		'{'{CMD_UNUSED,              4'd0,  32'sh7FFFFFFF}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd9,  32'shFFFFFFFF}, 1'b1, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd0,  32'sh80000000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd0,  32'sh80000000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b1, 32'sh7FFFFFFF},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd0,  32'sh7FFFFFFF}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd15, 32'sh00000000}, 1'b1, 32'sh80000000},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd0,  32'sh00010000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd0,  32'sh00010000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b1, 32'sh00010000},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd0,  32'shFFFFFFFF}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd0,  32'sh00000001}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b1, 32'shFFFFFFFF},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd15, 32'sh7FFFFFFF}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd15, 32'sh80000000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd3,  32'shFFFF8000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd12, 32'sh00030000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_LEFT,  4'd5,  32'sh12345678}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_LOAD_RIGHT, 4'd10, 32'shEDCBA988}, 1'b0, 32'sh00000000},
		'{'{mm4_pkg::CMD_MULTIPLY,   4'd0,  32'sh00000000}, 1'b0, 32'sh00000000}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	mm4_pkg::in_item_t item;
	logic strobe;
	mm4_pkg::out_item_t result;

	logic signed [31:0] left_m [CELLS];
	logic signed [31:0] right_m [CELLS];
	mm4_pkg::out_item_t pending_products [$];

	int errors = 0;
	int cycle_count = 0;
	int products_checked = 0;
	int loads_sent = 0;
	int multiplies_sent = 0;

	matrix_multiply_4x4 #(.DIM(DIM)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] product_entry(input int row, input int col);
		logic signed [65:0] acc;
		logic signed [65:0] scaled;
		longint term;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			term = longint'(left_m[row * DIM + k]) * longint'(right_m[k * DIM + col]);
			acc = acc + 66'(term);
		end
		scaled = acc >>> 16;
		if (scaled > 66'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (scaled < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return scaled[31:0];
	endfunction

	task automatic apply_beat(input mm4_pkg::in_item_t beat, input logic typed,
			input logic signed [31:0] value0);
		mm4_pkg::out_item_t prod;
		case (beat.command)
			mm4_pkg::CMD_LOAD_LEFT: begin
				loads_sent++;
				if (beat.element_index < CELLS) left_m[beat.element_index] = beat.element_value;
			end
			mm4_pkg::CMD_LOAD_RIGHT: begin
				loads_sent++;
				if (beat.element_index < CELLS) right_m[beat.element_index] = beat.element_value;
			end
			mm4_pkg::CMD_MULTIPLY: begin
				multiplies_sent++;
				for (int pos = 0; pos < CELLS; pos++) begin
					prod.product_index = 4'(pos);
					prod.product_value = product_entry(pos / DIM, pos % DIM);
					if (pos == 0 && typed) prod.product_value = value0;
					prod.last_element = (pos == CELLS - 1);
					pending_products.push_back(prod);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_beat(input mm4_pkg::in_item_t beat, input logic typed,
			input logic signed [31:0] value0);
		item <= beat;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_beat(beat, typed, value0);
	endtask

	task automatic sender_gaps(input int pct);
		logic [63:0] junk;
		while ($urandom_range(99) < pct) begin
			junk = {$urandom, $urandom};
			start <= 1'b0;
			item <= mm4_pkg::in_item_t'(junk[$bits(mm4_pkg::in_item_t)-1:0]);
			@(posedge clk);
		end
	endtask

	task automatic drain_products;
		start <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (MUL_CYCLES + 8) @(posedge clk);
	endtask

	function automatic mm4_pkg::in_item_t random_beat;
		mm4_pkg::in_item_t beat;
		logic [31:0] raw;
		int pick;
		raw = $urandom;
		pick = $urandom_range(99);
		if (pick < 46) beat.command = mm4_pkg::CMD_LOAD_LEFT;
		else if (pick < 92) beat.command = mm4_pkg::CMD_LOAD_RIGHT;
		else if (pick < 97) beat.command = mm4_pkg::CMD_MULTIPLY;
		else beat.command = CMD_UNUSED;
		beat.element_index = 4'($urandom_range(CELLS - 1));
		case ($urandom_range(3))
			0: beat.element_value = raw;
			1: beat.element_value = {{12{raw[19]}}, raw[19:0]};
			2: beat.element_value = {{8{raw[23]}}, raw[23:0]};
			default: begin
				case ($urandom_range(4))
					0: beat.element_value = 32'sh7FFFFFFF;
					1: beat.element_value = 32'sh80000000;
					2: beat.element_value = 32'sh00010000;
					3: beat.element_value = 32'shFFFF0000;
					default: beat.element_value = '0;
				endcase
			end
		endcase
		return beat;
	endfunction

	always @(posedge clk) begin
		mm4_pkg::out_item_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
			if (strobe) begin
				if (pending_products.size() == 0) begin
					$error("unexpected product beat: index %0d value %h last %0b",
						result.product_index, result.product_value, result.last_element);
					errors++;
				end else begin
					want = pending_products.pop_front();
					products_checked++;
					if (result.product_index !== want.product_index) begin
						$error("product_index: expected %0d, actual %0d",
							want.product_index, result.product_index);
						errors++;
					end
					if (result.product_value !== want.product_value) begin
						$error("product_value: expected %h, actual %h",
							want.product_value, result.product_value);
						errors++;
					end
					if (result.last_element !== want.last_element) begin
						$error("last_element: expected %0b, actual %0b",
							want.last_element, result.last_element);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int idle_pct [3];
		int sent;
		mm4_pkg::in_item_t beat;
		idle_pct = '{0, 76, 27};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		for (int i = 0; i < CELLS; i++) begin
			left_m[i] = '0;
			right_m[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].value0);
		end
		drain_products();

		for (int ph = 0; ph < 3; ph++) begin
			sent = 0;
			while (sent < RANDOM_BEATS / 3 + 1) begin
				sender_gaps(idle_pct[ph]);
				beat = random_beat();
				send_beat(beat, 1'b0, '0);
				if (beat.command != CMD_UNUSED) sent++;
			end
			drain_products();
		end

		if (pending_products.size() != 0) begin
			$error("%0d product beats never arrived", pending_products.size());
			errors++;
		end
		$display("Sent %0d load beats and %0d multiply beats; checked %0d product beats.",
			loads_sent, multiplies_sent, products_checked);
		$display("Covered saturation both ways, floor rounding, unused commands and idle gaps.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/mm4_pkg.sv
rtl/matrix_multiply_4x4.sv
verif/tb_matrix_multiply_4x4.sv
